// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// The consequent must hold later than the antecedent, as a delayed implication.
`define CHK_DELAY2(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("two-cycle implication failed");

`endif

// ----- hdl/rvbd_pkg.sv -----
// ----------------------------------------------------------------------------
// rvbd_pkg
// Shared codes, masks and types of the base instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rvbd_pkg;

  // Instruction format codes.
  localparam logic [2:0] FMT_R = 3'd0;
  localparam logic [2:0] FMT_I = 3'd1;
  localparam logic [2:0] FMT_S = 3'd2;
  localparam logic [2:0] FMT_B = 3'd3;
  localparam logic [2:0] FMT_U = 3'd4;
  localparam logic [2:0] FMT_J = 3'd5;
  localparam logic [2:0] FMT_X = 3'd6;

  // ALU operation codes used directly by the decoder.
  localparam logic [2:0] ALU_ADD  = 3'd0;
  localparam logic [2:0] ALU_SLT  = 3'd2;
  localparam logic [2:0] ALU_SLTU = 3'd3;

  localparam logic [3:0] MEM_NONE        = 4'd0;
  localparam logic [3:0] MEM_SIGNED_BASE = 4'd1;
  localparam logic [3:0] MEM_STORE_BASE  = 4'd5;

  // Major opcodes, bits 6..2 of the word.
  localparam logic [4:0] OP_LOAD   = 5'd0;
  localparam logic [4:0] OP_IMM    = 5'd4;
  localparam logic [4:0] OP_AUIPC  = 5'd5;
  localparam logic [4:0] OP_STORE  = 5'd8;
  localparam logic [4:0] OP_OP     = 5'd12;
  localparam logic [4:0] OP_LUI    = 5'd13;
  localparam logic [4:0] OP_BRANCH = 5'd24;
  localparam logic [4:0] OP_JAL    = 5'd27;
  localparam logic [4:0] OP_SYSTEM = 5'd28;

  localparam logic [1:0] LEN_32BIT = 2'b11;

  // Compare masks and fixed codes.
  localparam logic [31:0] MASK_F3     = 32'h0000_707f;
  localparam logic [31:0] MASK_F7     = 32'hfe00_707f;
  localparam logic [31:0] MASK_OP     = 32'h0000_007f;
  localparam logic [31:0] MASK_ALL    = 32'hffff_ffff;
  localparam logic [31:0] CODE_EBREAK = 32'h0010_0073;
  localparam logic [31:0] CODE_ECALL  = 32'h0000_0073;

  // Control flag bits, LSB first.
  localparam int unsigned FLAG_W = 15;
  localparam logic [FLAG_W-1:0] FL_ALUSRC = 15'h0001;
  localparam logic [FLAG_W-1:0] FL_REGW   = 15'h0002;
  localparam logic [FLAG_W-1:0] FL_MEMR   = 15'h0004;
  localparam logic [FLAG_W-1:0] FL_MEMW   = 15'h0008;
  localparam logic [FLAG_W-1:0] FL_MEM    = 15'h0010;
  localparam logic [FLAG_W-1:0] FL_RS1    = 15'h0020;
  localparam logic [FLAG_W-1:0] FL_RS2    = 15'h0040;
  localparam logic [FLAG_W-1:0] FL_MOD    = 15'h0080;
  localparam logic [FLAG_W-1:0] FL_BR     = 15'h0100;
  localparam logic [FLAG_W-1:0] FL_BNOT   = 15'h0200;
  localparam logic [FLAG_W-1:0] FL_JUMP   = 15'h0400;
  localparam logic [FLAG_W-1:0] FL_PC     = 15'h0800;
  localparam logic [FLAG_W-1:0] FL_EXC    = 15'h1000;
  localparam logic [FLAG_W-1:0] FL_ECALL  = 15'h2000;
  localparam logic [FLAG_W-1:0] FL_EBRK   = 15'h4000;

  // Decoded control group handed from the decode tree to the top level.
  typedef struct packed {
    logic              supported;
    logic [2:0]        fmt;
    logic [2:0]        alu;
    logic [3:0]        mem;
    logic [FLAG_W-1:0] flags;
  } rvbd_dec_t;

endpackage

`default_nettype wire

// ----- hdl/rvbd_decode.sv -----
// ----------------------------------------------------------------------------
// rvbd_decode
// Decode tree: opcode, funct3, bit 30 and bit 20 select a leaf; the word is
// then checked against the leaf's code under its mask.
// ----------------------------------------------------------------------------
`default_nettype none

module rvbd_decode (
  input  logic [31:0]        word,
  output rvbd_pkg::rvbd_dec_t dec
);
  import rvbd_pkg::*;

  logic [4:0]  op5;
  logic [2:0]  f3;
  logic        b30;
  logic        real_leaf;
  logic [31:0] code;
  logic [31:0] mask;
  logic [31:0] op_f3_code;

  assign op5        = word[6:2];
  assign f3         = word[14:12];
  assign b30        = word[30];
  assign op_f3_code = {17'b0, f3, 5'b0, op5, LEN_32BIT};

  always_comb begin
    dec.fmt   = FMT_X;
    dec.alu   = ALU_ADD;
    dec.mem   = MEM_NONE;
    dec.flags = '0;
    code      = '0;
    mask      = '0;
    real_leaf = 1'b0;
    if (word[1:0] == LEN_32BIT) begin
      unique case (op5)
        OP_LOAD: begin
          if (f3 != 3'd7) begin
            real_leaf = 1'b1;
            dec.fmt   = FMT_I;
            dec.mem   = {1'b0, f3} + MEM_SIGNED_BASE;
            dec.flags = FL_ALUSRC | FL_REGW | FL_MEMR | FL_MEM | FL_RS1;
            code      = op_f3_code;
            mask      = MASK_F3;
          end
        end
        OP_IMM: begin
          real_leaf = 1'b1;
          dec.fmt   = FMT_I;
          dec.alu   = f3;
          dec.flags = FL_ALUSRC | FL_REGW | FL_RS1;
          code      = op_f3_code;
          mask      = MASK_F3;
          if (f3 == 3'd1) begin
            mask = MASK_F7;
          end
          if (f3 == 3'd5) begin
            mask     = MASK_F7;
            code[30] = b30;
            if (b30) begin
              dec.flags = dec.flags | FL_MOD;
            end
          end
        end
        OP_AUIPC: begin
          real_leaf = 1'b1;
          dec.fmt   = FMT_U;
          dec.flags = FL_ALUSRC | FL_REGW | FL_PC;
          code      = op_f3_code & MASK_OP;
          mask      = MASK_OP;
        end
        OP_STORE: begin
          if (!f3[2]) begin
            real_leaf = 1'b1;
            dec.fmt   = FMT_S;
            dec.mem   = {1'b0, f3} + MEM_STORE_BASE;
            dec.flags = FL_ALUSRC | FL_MEMW | FL_MEM | FL_RS1 | FL_RS2;
            code      = op_f3_code;
            mask      = MASK_F3;
          end
        end
        OP_OP: begin
          real_leaf = 1'b1;
          dec.fmt   = FMT_R;
          dec.alu   = f3;
          dec.flags = FL_REGW | FL_RS1 | FL_RS2;
          code      = op_f3_code;
          mask      = MASK_F7;
          if (f3 == 3'd0 || f3 == 3'd5) begin
            code[30] = b30;
            if (b30) begin
              dec.flags = dec.flags | FL_MOD;
            end
          end
        end
        OP_LUI: begin
          real_leaf = 1'b1;
          dec.fmt   = FMT_U;
          dec.flags = FL_ALUSRC | FL_REGW;
          code      = op_f3_code & MASK_OP;
          mask      = MASK_OP;
        end
        OP_BRANCH: begin
          if (f3 != 3'd2 && f3 != 3'd3) begin
            real_leaf = 1'b1;
            dec.fmt   = FMT_B;
            dec.flags = FL_BR | FL_RS1 | FL_RS2;
            unique case (f3) inside
              3'd0, 3'd1: begin
                dec.alu   = ALU_ADD;
                dec.flags = dec.flags | FL_MOD;
              end
              3'd4, 3'd5: dec.alu = ALU_SLT;
              default:    dec.alu = ALU_SLTU;
            endcase
            if (f3[0]) begin
              dec.flags = dec.flags | FL_BNOT;
            end
            code = op_f3_code;
            mask = MASK_F3;
          end
        end
        OP_JAL: begin
          real_leaf = 1'b1;
          dec.fmt   = FMT_J;
          dec.flags = FL_REGW | FL_JUMP | FL_PC | FL_ALUSRC;
          code      = op_f3_code & MASK_OP;
          mask      = MASK_OP;
        end
        OP_SYSTEM: begin
          real_leaf = 1'b1;
          dec.fmt   = FMT_I;
          mask      = MASK_ALL;
          if (word[20]) begin
            code      = CODE_EBREAK;
            dec.flags = FL_EXC | FL_EBRK;
          end else begin
            code      = CODE_ECALL;
            dec.flags = FL_EXC | FL_ECALL;
          end
        end
        default: begin
          real_leaf = 1'b0;
        end
      endcase
    end
    dec.supported = real_leaf && (((word ^ code) & mask) == 32'd0);
  end

endmodule

`default_nettype wire

// ----- hdl/rvbd_imm_gen.sv -----
// ----------------------------------------------------------------------------
// rvbd_imm_gen
// Sign-extended immediate for the decoded instruction format.
// ----------------------------------------------------------------------------
`default_nettype none

module rvbd_imm_gen (
  input  logic [31:0]        word,
  input  logic [2:0]         fmt,
  output logic signed [31:0] imm
);
  import rvbd_pkg::*;

  logic s;

  assign s = word[31];

  always_comb begin
    unique case (fmt)
      FMT_I:   imm = {{20{s}}, word[31:20]};
      FMT_S:   imm = {{20{s}}, word[31:25], word[11:7]};
      // The branch offset takes its sign from bit 31, landing at bit 12.
      FMT_B:   imm = {{19{s}}, s, word[7], word[30:25], word[11:8], 1'b0};
      FMT_U:   imm = {word[31:12], 12'b0};
      FMT_J:   imm = {{11{s}}, s, word[19:12], word[20], word[30:21], 1'b0};
      default: imm = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/rv_base_instruction_decoder_core.sv -----
// ----------------------------------------------------------------------------
// rv_base_instruction_decoder_core
// Base integer instruction decoder, one 32-bit word per cycle outside reset.
// ----------------------------------------------------------------------------
// Usage:
//   A request is one raw instruction word on in_instr_word. It is taken at a
//   rising clock edge where start is high and busy is low. Outside reset busy
//   stays low, so a new word can be given in every cycle.
//   The word lands in an input register; the decode tree and the immediate
//   generator work on it in the following cycle and their outputs are caught
//   in the result register. The result is on the out_ ports, marked by
//   out_valid, for exactly one cycle: it appears at the edge after the request
//   edge and is taken at the edge that ends that cycle.
//   Throughput is one word per cycle outside reset; the input register and
//   the result register lie around the single decode pass.
//   The receiver cannot hold results off: every result is shown once and is
//   gone at the next edge, so a downstream stage must take it then.
//   The block keeps no decode state. Synchronous reset (rst_n low) clears the
//   two valid flags, so no stale result appears, and holds busy high while
//   reset is applied; busy drops at the first edge that samples rst_n high.
// ----------------------------------------------------------------------------
`default_nettype none

module rv_base_instruction_decoder_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        in_instr_word,
  output logic               out_valid,
  output logic               out_supported,
  output logic [2:0]         out_inst_format,
  output logic [2:0]         out_alu_operation,
  output logic [3:0]         out_memory_access,
  output logic [14:0]        out_control_flags,
  output logic signed [31:0] out_immediate_value,
  output logic [4:0]         out_dest_reg,
  output logic [4:0]         out_src1_reg,
  output logic [4:0]         out_src2_reg
);
  import rvbd_pkg::*;

  // Control registers.
  logic busy_r;
  logic in_valid_r;
  logic out_valid_r;

  // Payload registers.
  logic [31:0]        word_r;
  rvbd_dec_t          dec_r;
  logic signed [31:0] imm_r;
  logic [4:0]         rd_r;
  logic [4:0]         rs1_r;
  logic [4:0]         rs2_r;

  // Decode pass outputs.
  rvbd_dec_t          dec_nxt;
  logic signed [31:0] imm_nxt;
  logic               accept;

  assign accept = start && !busy_r;

  // Busy is raised only while reset is applied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      in_valid_r  <= accept;
      out_valid_r <= in_valid_r;
    end
  end

  // Input register: the word is captured on each accepted request.
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r <= in_instr_word;
    end
  end

  rvbd_decode u_decode (
    .word (word_r),
    .dec  (dec_nxt)
  );

  rvbd_imm_gen u_imm_gen (
    .word (word_r),
    .fmt  (dec_nxt.fmt),
    .imm  (imm_nxt)
  );

  // Result register. The register fields are plain slices of the word.
  always_ff @(posedge clk) begin
    if (in_valid_r) begin
      dec_r <= dec_nxt;
      imm_r <= imm_nxt;
      rd_r  <= word_r[11:7];
      rs1_r <= word_r[19:15];
      rs2_r <= word_r[24:20];
    end
  end

  assign busy                = busy_r;
  assign out_valid           = out_valid_r;
  assign out_supported       = dec_r.supported;
  assign out_inst_format     = dec_r.fmt;
  assign out_alu_operation   = dec_r.alu;
  assign out_memory_access   = dec_r.mem;
  assign out_control_flags   = dec_r.flags;
  assign out_immediate_value = imm_r;
  assign out_dest_reg        = rd_r;
  assign out_src1_reg        = rs1_r;
  assign out_src2_reg        = rs2_r;

endmodule

`default_nettype wire

// ----- hdl/rvbd_checker.sv -----
// ----------------------------------------------------------------------------
// rvbd_checker
// Port-level checks of the decoder's timing and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rvbd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [31:0]        in_instr_word,
  input logic               out_valid,
  input logic               out_supported,
  input logic [2:0]         out_inst_format,
  input logic signed [31:0] out_immediate_value,
  input logic [4:0]         out_src1_reg
);
  import rvbd_pkg::*;

  logic fmt_no_imm;

  assign fmt_no_imm = (out_inst_format == FMT_R) || (out_inst_format == FMT_X);

  // Every accepted request yields a result on out_valid.
  `CHK_DELAY2(a_req_to_result, clk, rst_n, start && !busy, out_valid)

  // A result carries the source field of the word whose request it answers.
  `CHK_IMPL(a_rs1_match, clk, rst_n, out_valid, out_src1_reg == $past(in_instr_word[19:15], 2))

  // A supported word never decodes to the unknown format.
  `CHK_IMPL(a_supported_known, clk, rst_n, out_valid && out_supported, out_inst_format != FMT_X)

  // Register-register and unknown formats carry no immediate.
  `CHK_IMPL(a_no_imm, clk, rst_n, out_valid && fmt_no_imm, out_immediate_value == 32'sd0)

endmodule

bind rv_base_instruction_decoder_core rvbd_checker u_rvbd_checker (.*);

`default_nettype wire

// ----- dv/rvbd_decode_checker.sv -----
// ----------------------------------------------------------------------------
// rvbd_decode_checker
// Watches the request and result ports of the base instruction decoder,
// predicts the decode of every accepted word and compares the results in
// order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

package rvbd_tb_pkg;

  import rvbd_pkg::*;

  // funct3 values that steer the decode tree.
  localparam logic [2:0] F3_ADD_SUB    = 3'd0;
  localparam logic [2:0] F3_SLL        = 3'd1;
  localparam logic [2:0] F3_SHR        = 3'd5;
  localparam logic [2:0] F3_BYTE       = 3'd0;
  localparam logic [2:0] F3_DOUBLE     = 3'd3;
  localparam logic [2:0] F3_LOAD_RSVD  = 3'd7;
  localparam logic [2:0] F3_STORE_RSVD = 3'd4;
  localparam logic [2:0] F3_BEQ        = 3'd0;
  localparam logic [2:0] F3_BNE        = 3'd1;
  localparam logic [2:0] F3_BR_RSVD    = 3'd2;
  localparam logic [2:0] F3_BLT        = 3'd4;
  localparam logic [2:0] F3_BGE        = 3'd5;
  localparam logic [2:0] F3_BLTU       = 3'd6;
  localparam logic [2:0] F3_BGEU       = 3'd7;
  localparam logic [2:0] F3_CSRRW      = 3'd1;

  // funct7 values for the register and shift forms.
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // Major opcode that the decoder does not handle.
  localparam logic [4:0] OP_JALR = 5'd25;

endpackage

module rvbd_decode_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic [31:0]        in_instr_word,
  input  wire logic               out_valid,
  input  wire logic               out_supported,
  input  wire logic [2:0]         out_inst_format,
  input  wire logic [2:0]         out_alu_operation,
  input  wire logic [3:0]         out_memory_access,
  input  wire logic [14:0]        out_control_flags,
  input  wire logic signed [31:0] out_immediate_value,
  input  wire logic [4:0]         out_dest_reg,
  input  wire logic [4:0]         out_src1_reg,
  input  wire logic [4:0]         out_src2_reg,
  output int                      fail_count,
  output int                      outstanding,
  output int                      compared,
  output int                      supported_seen
);
  import rvbd_pkg::*;
  import rvbd_tb_pkg::*;

  typedef struct {
    logic              supported;
    logic [2:0]        fmt;
    logic [2:0]        alu;
    logic [3:0]        mem;
    logic [FLAG_W-1:0] flags;
    logic [31:0]       imm;
    logic [4:0]        rd;
    logic [4:0]        rs1;
    logic [4:0]        rs2;
  } decode_t;

  decode_t pending_decodes[$];

  function automatic decode_t decode_word(input logic [31:0] w);
    decode_t     d;
    logic [4:0]  op5;
    logic [2:0]  f3;
    logic [31:0] code;
    logic [31:0] mask;
    logic        is_leaf;
    op5 = w[6:2];
    f3 = w[14:12];
    d.fmt = FMT_X;
    d.alu = ALU_ADD;
    d.mem = MEM_NONE;
    d.flags = '0;
    code = {17'd0, f3, 5'd0, op5, LEN_32BIT};
    mask = '0;
    is_leaf = (w[1:0] == LEN_32BIT);
    if (is_leaf) begin
      case (op5)
        OP_LOAD: begin
          is_leaf = (f3 != F3_LOAD_RSVD);
          d.fmt = FMT_I;
          d.mem = MEM_SIGNED_BASE + {1'b0, f3};
          d.flags = FL_ALUSRC | FL_REGW | FL_MEMR | FL_MEM | FL_RS1;
          mask = MASK_F3;
        end
        OP_IMM: begin
          d.fmt = FMT_I;
          d.alu = f3;
          d.flags = FL_ALUSRC | FL_REGW | FL_RS1;
          mask = (f3 == F3_SLL || f3 == F3_SHR) ? MASK_F7 : MASK_F3;
          if (f3 == F3_SHR) begin
            code[30] = w[30];
            if (w[30]) d.flags |= FL_MOD;
          end
        end
        OP_AUIPC: begin
          d.fmt = FMT_U;
          d.flags = FL_ALUSRC | FL_REGW | FL_PC;
          mask = MASK_OP;
        end
        OP_STORE: begin
          is_leaf = (f3 < F3_STORE_RSVD);
          d.fmt = FMT_S;
          d.mem = MEM_STORE_BASE + {1'b0, f3};
          d.flags = FL_ALUSRC | FL_MEMW | FL_MEM | FL_RS1 | FL_RS2;
          mask = MASK_F3;
        end
        OP_OP: begin
          d.fmt = FMT_R;
          d.alu = f3;
          d.flags = FL_REGW | FL_RS1 | FL_RS2;
          mask = MASK_F7;
          if (f3 == F3_ADD_SUB || f3 == F3_SHR) begin
            code[30] = w[30];
            if (w[30]) d.flags |= FL_MOD;
          end
        end
        OP_LUI: begin
          d.fmt = FMT_U;
          d.flags = FL_ALUSRC | FL_REGW;
          mask = MASK_OP;
        end
        OP_BRANCH: begin
          d.fmt = FMT_B;
          d.flags = FL_BR | FL_RS1 | FL_RS2;
          case (f3)
            F3_BEQ, F3_BNE: begin
              d.alu = ALU_ADD;
              d.flags |= FL_MOD;
            end
            F3_BLT, F3_BGE: d.alu = ALU_SLT;
            F3_BLTU, F3_BGEU: d.alu = ALU_SLTU;
            default: is_leaf = 1'b0;
          endcase
          if (f3 == F3_BNE || f3 == F3_BGE || f3 == F3_BGEU) d.flags |= FL_BNOT;
          mask = MASK_F3;
        end
        OP_JAL: begin
          d.fmt = FMT_J;
          d.flags = FL_REGW | FL_JUMP | FL_PC | FL_ALUSRC;
          mask = MASK_OP;
        end
        OP_SYSTEM: begin
          d.fmt = FMT_I;
          mask = MASK_ALL;
          if (w[20]) begin
            code = CODE_EBREAK;
            d.flags = FL_EXC | FL_EBRK;
          end else begin
            code = CODE_ECALL;
            d.flags = FL_EXC | FL_ECALL;
          end
        end
        default: is_leaf = 1'b0;
      endcase
    end
    // A dead end of the tree gives the unknown leaf, whatever was filled in.
    if (!is_leaf) begin
      d.fmt = FMT_X;
      d.alu = ALU_ADD;
      d.mem = MEM_NONE;
      d.flags = '0;
    end
    d.supported = is_leaf && (((w ^ code) & mask) == '0);
    case (d.fmt)
      FMT_I: d.imm = {{20{w[31]}}, w[31:20]};
      FMT_S: d.imm = {{20{w[31]}}, w[31:25], w[11:7]};
      FMT_B: d.imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      FMT_U: d.imm = {w[31:12], 12'd0};
      FMT_J: d.imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      default: d.imm = '0;
    endcase
    d.rd = w[11:7];
    d.rs1 = w[19:15];
    d.rs2 = w[24:20];
    return d;
  endfunction

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // Results are retired before new requests are queued; with the input and
  // result registers between them, a result never belongs to the same edge's request.
  always @(posedge clk) begin
    decode_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (pending_decodes.size() == 0) begin
          $error("decode result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = pending_decodes.pop_front();
          compared++;
          if (want.supported) supported_seen++;
          compare_field("supported", 32'(want.supported), 32'(out_supported));
          compare_field("inst_format", 32'(want.fmt), 32'(out_inst_format));
          compare_field("alu_operation", 32'(want.alu), 32'(out_alu_operation));
          compare_field("memory_access", 32'(want.mem), 32'(out_memory_access));
          compare_field("control_flags", 32'(want.flags), 32'(out_control_flags));
          compare_field("immediate_value", want.imm, out_immediate_value);
          compare_field("dest_reg", 32'(want.rd), 32'(out_dest_reg));
          compare_field("src1_reg", 32'(want.rs1), 32'(out_src1_reg));
          compare_field("src2_reg", 32'(want.rs2), 32'(out_src2_reg));
        end
      end
      if (start && !busy) pending_decodes.push_back(decode_word(in_instr_word));
      outstanding = pending_decodes.size();
    end
  end

endmodule

`default_nettype wire

// ----- dv/tb_rv_base_instruction_decoder_core.sv -----
// ----------------------------------------------------------------------------
// tb_rv_base_instruction_decoder_core
// Testbench of the base instruction decoder. A short directed list walks
// every opcode, the dead ends of the decode tree and the immediate extremes;
// then a long random stream, mostly well-formed words with random content,
// goes in bursts with random gaps. The checker predicts and compares each
// decode; this module drives requests and gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rv_base_instruction_decoder_core;

  import rvbd_pkg::*;
  import rvbd_tb_pkg::*;

  localparam int RANDOM_WORDS = 900;
  // Extra wait after the last result, to catch any stray strobe.
  localparam int LATENCY_TAIL = 4;
  localparam int DRAIN_LIMIT  = 200;

  // Opcodes that lead to a real leaf; the random stream draws from these.
  localparam logic [4:0] LEAF_OPS [9] = '{OP_LOAD, OP_IMM, OP_AUIPC, OP_STORE,
                                          OP_OP, OP_LUI, OP_BRANCH, OP_JAL,
                                          OP_SYSTEM};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        in_instr_word = '0;
  logic               out_valid;
  logic               out_supported;
  logic [2:0]         out_inst_format;
  logic [2:0]         out_alu_operation;
  logic [3:0]         out_memory_access;
  logic [14:0]        out_control_flags;
  logic signed [31:0] out_immediate_value;
  logic [4:0]         out_dest_reg;
  logic [4:0]         out_src1_reg;
  logic [4:0]         out_src2_reg;

  int fail_count;
  int outstanding;
  int compared;
  int supported_seen;
  int words_sent = 0;

  always #5 clk = ~clk;

  rv_base_instruction_decoder_core i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_instr_word       (in_instr_word),
    .out_valid           (out_valid),
    .out_supported       (out_supported),
    .out_inst_format     (out_inst_format),
    .out_alu_operation   (out_alu_operation),
    .out_memory_access   (out_memory_access),
    .out_control_flags   (out_control_flags),
    .out_immediate_value (out_immediate_value),
    .out_dest_reg        (out_dest_reg),
    .out_src1_reg        (out_src1_reg),
    .out_src2_reg        (out_src2_reg)
  );

  rvbd_decode_checker i_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_instr_word       (in_instr_word),
    .out_valid           (out_valid),
    .out_supported       (out_supported),
    .out_inst_format     (out_inst_format),
    .out_alu_operation   (out_alu_operation),
    .out_memory_access   (out_memory_access),
    .out_control_flags   (out_control_flags),
    .out_immediate_value (out_immediate_value),
    .out_dest_reg        (out_dest_reg),
    .out_src1_reg        (out_src1_reg),
    .out_src2_reg        (out_src2_reg),
    .fail_count          (fail_count),
    .outstanding         (outstanding),
    .compared            (compared),
    .supported_seen      (supported_seen)
  );

  // Packs the standard R-type field layout. Immediate formats reuse the same
  // slots, so the other encodings are built by choosing the fields to match.
  function automatic logic [31:0] pack_word(input logic [6:0] f7, input logic [4:0] rs2,
                                            input logic [4:0] rs1, input logic [2:0] f3,
                                            input logic [4:0] rd, input logic [4:0] op5);
    return {f7, rs2, rs1, f3, rd, op5, LEN_32BIT};
  endfunction

  // Roughly seven words in ten are well-formed: a real opcode, a funct7 that
  // for most register and shift forms is either the base or the alternate code,
  // and an exact ecall or ebreak for most system words. The rest is raw
  // noise, which covers compressed words and unlisted opcodes.
  function automatic logic [31:0] random_word();
    logic [31:0] w;
    logic [4:0]  op5;
    w = $urandom();
    if ($urandom_range(9) < 3) return w;
    op5 = LEAF_OPS[$urandom_range(8)];
    w[6:0] = {op5, LEN_32BIT};
    case (op5)
      OP_IMM, OP_OP: begin
        if ($urandom_range(7) != 0) w[31:25] = $urandom_range(1) ? F7_ALT : F7_BASE;
      end
      OP_SYSTEM: begin
        if ($urandom_range(3) != 0) w = $urandom_range(1) ? CODE_EBREAK : CODE_ECALL;
      end
      default: ;
    endcase
    return w;
  endfunction

  // Holds start high and presents one word until the block takes it. A word
  // that follows in the same burst keeps start high, so start is never
  // lowered and raised within one edge.
  task automatic send_word(input logic [31:0] w);
    start <= 1'b1;
    in_instr_word <= w;
    do @(posedge clk); while (busy);
    words_sent++;
  endtask

  task automatic pause(input int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Stops sending until every request has come back as a result, or the
  // limit runs out. The count is sampled at the falling edge, away from the
  // checker's updates, and driving resumes at the next rising edge.
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    do begin
      @(negedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    @(posedge clk);
  endtask

  // Directed words: each opcode, a word for each kind of dead end of the tree,
  // the supported bit cleared by stray funct7 or system bits, and immediates
  // at both signs and at their largest magnitudes.
  task automatic run_directed();
    send_word(32'h0000_0000);                                       // compressed, all zero
    send_word(32'hffff_ffff);                                       // unlisted opcode
    send_word(32'h0000_4501);                                       // compressed, low bits 01
    send_word(pack_word(7'h7f, 5'h1f, 5'h1f, 3'd7, 5'd1, OP_LUI));  // lui, top bits set
    send_word(pack_word(F7_BASE, 5'd0, 5'd0, 3'd1, 5'd2, OP_AUIPC));
    send_word(pack_word(7'h40, 5'd0, 5'd0, 3'd0, 5'd1, OP_JAL));    // jal, most negative
    send_word(pack_word(7'h3f, 5'h1f, 5'h1f, 3'd7, 5'd0, OP_JAL));  // jal, largest
    send_word(pack_word(F7_BASE, 5'd0, 5'd1, F3_ADD_SUB, 5'd1, OP_JALR));
    send_word(pack_word(7'h40, 5'd0, 5'd1, F3_BYTE, 5'd1, OP_LOAD));
    send_word(pack_word(F7_BASE, 5'd0, 5'd1, F3_LOAD_RSVD, 5'd1, OP_LOAD));
    send_word(pack_word(7'h7f, 5'd2, 5'd1, F3_DOUBLE, 5'h1f, OP_STORE));
    send_word(pack_word(F7_BASE, 5'd2, 5'd1, F3_STORE_RSVD, 5'd0, OP_STORE));
    send_word(pack_word(7'h7f, 5'h1f, 5'd3, F3_ADD_SUB, 5'd3, OP_IMM)); // addi -1
    send_word(pack_word(F7_MULDIV, 5'd4, 5'd3, F3_SLL, 5'd3, OP_IMM));  // slli, bad funct7
    send_word(pack_word(F7_ALT, 5'h1f, 5'd3, F3_SHR, 5'd3, OP_IMM));    // srai
    send_word(pack_word(F7_ALT, 5'd5, 5'd6, F3_ADD_SUB, 5'd7, OP_OP));  // sub
    send_word(pack_word(F7_ALT, 5'd5, 5'd6, F3_SHR, 5'd7, OP_OP));      // sra
    send_word(pack_word(F7_MULDIV, 5'd5, 5'd6, F3_ADD_SUB, 5'd7, OP_OP));
    send_word(pack_word(7'h7f, 5'd2, 5'd1, F3_BEQ, 5'h1f, OP_BRANCH));  // offset -2
    send_word(pack_word(7'h3f, 5'd2, 5'd1, F3_BNE, 5'h1e, OP_BRANCH));  // positive
    send_word(pack_word(F7_BASE, 5'd2, 5'd1, F3_BGEU, 5'd8, OP_BRANCH));
    send_word(pack_word(F7_BASE, 5'd2, 5'd1, F3_BR_RSVD, 5'd8, OP_BRANCH));
    send_word(CODE_ECALL);
    send_word(CODE_EBREAK);
    send_word(CODE_ECALL | pack_word(F7_BASE, 5'd0, 5'd0, F3_CSRRW, 5'd1, OP_SYSTEM));
  endtask

  // Random stream in bursts. About one burst in four has no gap after it, so
  // long back-to-back stretches occur; after the others the sender pauses, so
  // gaps land on every phase of the two-stage pipeline. Half way through the
  // sender drains the block completely once more.
  task automatic run_random();
    int burst_left;
    burst_left = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) drain();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(3) != 0) pause($urandom_range(1, 6));
      end
      send_word(random_word());
      burst_left--;
    end
  endtask

  initial begin
    int waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain();
    run_random();
    start <= 1'b0;
    // Wait for the last results, then wait out LATENCY_TAIL to catch any stray
    // strobe after the final one.
    waited = 0;
    do begin
      @(negedge clk);
      waited++;
    end while (outstanding != 0 && waited < DRAIN_LIMIT);
    repeat (LATENCY_TAIL) @(negedge clk);
    if (outstanding != 0) $error("%0d decode results never arrived", outstanding);
    $display("Sent %0d instruction words; %0d decodes compared, %0d of them supported.",
             words_sent, compared, supported_seen);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_rv_base_instruction_decoder_core passed");
    end else begin
      $display("tb_rv_base_instruction_decoder_core failed");
    end
    $finish;
  end

  // This bound is far beyond the length of the full run.
  initial begin
    #1000000;
    $display("tb_rv_base_instruction_decoder_core failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
+incdir+hdl
hdl/rvbd_pkg.sv
hdl/rvbd_decode.sv
hdl/rvbd_imm_gen.sv
hdl/rv_base_instruction_decoder_core.sv
hdl/rvbd_checker.sv
dv/rvbd_decode_checker.sv
dv/tb_rv_base_instruction_decoder_core.sv
